// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers. They compile to nothing when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, conseq)
`define ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

// ===== rtl/core/lzwc_pkg.sv =====
// ---------------------------------------------------------------------------
// LZW compressor package
// Shared constants, the result word type and the FIFO push type.
// ---------------------------------------------------------------------------
package lzwc_pkg;
   localparam int CODE_BITS_DEFAULT = 12;
   localparam int LITERALS          = 256;
   localparam int CODE_W            = 12;
   localparam int EPOCH_BITS        = 4;
   localparam int FIFO_DEPTH        = 4;
   localparam int FIFO_AW           = 2;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              last_code;
   } rsp_word_type;

   typedef struct packed {
      logic         push0;
      rsp_word_type word0;
      logic         push1;
      rsp_word_type word1;
   } fifo_push_type;
endpackage

// ===== rtl/core/lzwc_dict_ram.sv =====
// ---------------------------------------------------------------------------
// Dictionary RAM
// Simple dual-port synchronous RAM with a registered read port.
// ---------------------------------------------------------------------------
module lzwc_dict_ram #(
   parameter int ADDR_BITS = 13,
   parameter int DATA_BITS = 36
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);
   logic [DATA_BITS-1:0] mem [0:(1<<ADDR_BITS)-1];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/lzwc_rsp_fifo.sv =====
// ---------------------------------------------------------------------------
// Result FIFO
// Four-word queue that takes up to two words per cycle and drives rsp_.
// ---------------------------------------------------------------------------
module lzwc_rsp_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  lzwc_pkg::fifo_push_type      push,
   output logic                         out_valid,
   input  logic                         out_stall,
   output lzwc_pkg::rsp_word_type       out_word,
   output logic [lzwc_pkg::FIFO_AW:0]   count
);
   lzwc_pkg::rsp_word_type         slots_ff [0:lzwc_pkg::FIFO_DEPTH-1];
   logic [lzwc_pkg::FIFO_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in, wp1;
   logic [lzwc_pkg::FIFO_AW:0]     cnt_ff, cnt_in;
   logic                           pop;

   assign pop       = (cnt_ff != '0) && !out_stall;
   assign wp1       = wp_ff + lzwc_pkg::FIFO_AW'(push.push0);
   assign wp_in     = wp1 + lzwc_pkg::FIFO_AW'(push.push1);
   assign rp_in     = rp_ff + lzwc_pkg::FIFO_AW'(pop);
   assign cnt_in    = cnt_ff + (lzwc_pkg::FIFO_AW+1)'(push.push0)
                      + (lzwc_pkg::FIFO_AW+1)'(push.push1) - (lzwc_pkg::FIFO_AW+1)'(pop);
   assign out_valid = (cnt_ff != '0);
   assign out_word  = slots_ff[rp_ff];
   assign count     = cnt_ff;

   always_ff @(posedge clock) begin
      if (push.push0) begin
         slots_ff[wp_ff] <= push.word0;
      end
      if (push.push1) begin
         slots_ff[wp1] <= push.word1;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== rtl/core/lzw_byte_compressor_core.sv =====
// ---------------------------------------------------------------------------
// LZW byte compressor core
// Streaming LZW encoder with a hashed dictionary held in one RAM.
// ---------------------------------------------------------------------------
// Usage: bytes enter on the req_ channel, one word per byte, with
// req_end_of_stream set on the final byte of a stream. Codes leave on the
// rsp_ channel; rsp_last_code marks the final code of a stream.
// Each byte is looked up as a (prefix, byte) pair in a hash table of
// 2^(CODE_BITS+1) entries with linear probing. A byte that starts a stream
// needs no lookup; others loop over the RAM read port, one slot further per
// probe collision. A code enters the result queue when its lookup ends and
// appears on rsp_ after the codes queued ahead of it.
// Entries carry an epoch tag, so ending a stream invalidates the dictionary
// at once. After reset, and whenever the epoch tag wraps (every 15 streams),
// a clearing pass writes every table entry with req_stall held high.
// Results go into a four-word queue, so new bytes are taken while earlier
// codes wait; req_stall rises when the queue could not hold two more words.
// A stalled receiver therefore only blocks input once three words wait.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lzw_byte_compressor_core #(
   parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_end_of_stream,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [lzwc_pkg::CODE_W-1:0] rsp_code,
   output logic                      rsp_last_code
);
   localparam int H  = CODE_BITS + 1;
   localparam int EB = lzwc_pkg::EPOCH_BITS;
   localparam int DW = EB + CODE_BITS + 8 + CODE_BITS;

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PROBE} state_type;

   state_type             state_ff, state_in;
   logic [H-1:0]          clr_addr_ff, clr_addr_in;
   logic [EB-1:0]         epoch_ff, epoch_in;
   logic [CODE_BITS-1:0]  prefix_ff, prefix_in;
   logic                  prefix_valid_ff, prefix_valid_in;
   logic [CODE_BITS:0]    next_free_ff, next_free_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  eos_ff, eos_in;
   logic [H-1:0]          probe_addr_ff, probe_addr_in;

   logic                  accept;
   logic                  wr_en;
   logic [H-1:0]          wr_addr, rd_addr;
   logic [DW-1:0]         wr_data, rd_data;
   logic [EB-1:0]         ent_epoch;
   logic [CODE_BITS-1:0]  ent_prefix, ent_code;
   logic [7:0]            ent_byte;
   logic                  ent_live, ent_hit;
   logic [CODE_BITS-1:0]  final_prefix;
   logic                  end_stream;
   lzwc_pkg::fifo_push_type push;
   lzwc_pkg::rsp_word_type  out_word;
   logic [lzwc_pkg::FIFO_AW:0] fifo_count;

   // Hash of a (prefix, byte) pair: the byte lands in the top bits.
   function automatic logic [H-1:0] pair_hash(input logic [CODE_BITS-1:0] pre,
                                              input logic [7:0] b);
      pair_hash = H'(pre) ^ (H'(b) << (H - 8));
   endfunction

   assign req_stall = (state_ff != ST_IDLE) || (fifo_count > 3'(lzwc_pkg::FIFO_DEPTH - 2));
   assign accept    = req_valid && !req_stall;

   assign {ent_epoch, ent_prefix, ent_byte, ent_code} = rd_data;
   assign ent_live = (ent_epoch == epoch_ff);
   assign ent_hit  = ent_live && (ent_prefix == prefix_ff) && (ent_byte == byte_ff);

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      epoch_in        = epoch_ff;
      prefix_in       = prefix_ff;
      prefix_valid_in = prefix_valid_ff;
      next_free_in    = next_free_ff;
      byte_in         = byte_ff;
      eos_in          = eos_ff;
      probe_addr_in   = probe_addr_ff;
      rd_addr         = probe_addr_ff + H'(1);
      wr_en           = 1'b0;
      wr_addr         = clr_addr_ff;
      wr_data         = '0;
      push            = '0;
      final_prefix    = prefix_ff;
      end_stream      = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep every entry back to the invalid epoch.
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + H'(1);
            if (clr_addr_ff == '1) begin
               epoch_in = EB'(1);
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = pair_hash(prefix_ff, req_data_byte);
            if (accept) begin
               byte_in = req_data_byte;
               eos_in  = req_end_of_stream;
               if (!prefix_valid_ff) begin
                  // First byte of a stream only becomes the prefix.
                  prefix_in       = CODE_BITS'(req_data_byte);
                  prefix_valid_in = 1'b1;
                  final_prefix    = CODE_BITS'(req_data_byte);
                  end_stream      = req_end_of_stream;
               end else begin
                  probe_addr_in = rd_addr;
                  state_in      = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            priority if (ent_hit) begin
               prefix_in    = ent_code;
               final_prefix = ent_code;
               end_stream   = eos_ff;
               state_in     = ST_IDLE;
            end else if (ent_live) begin
               // Collision with another pair: try the next slot.
               probe_addr_in = rd_addr;
            end else begin
               push.push0           = 1'b1;
               push.word0.code      = lzwc_pkg::CODE_W'(prefix_ff);
               push.word0.last_code = 1'b0;
               if (!next_free_ff[CODE_BITS]) begin
                  wr_en        = 1'b1;
                  wr_addr      = probe_addr_ff;
                  wr_data      = {epoch_ff, prefix_ff, byte_ff, next_free_ff[CODE_BITS-1:0]};
                  next_free_in = next_free_ff + (CODE_BITS+1)'(1);
               end
               prefix_in    = CODE_BITS'(byte_ff);
               final_prefix = CODE_BITS'(byte_ff);
               end_stream   = eos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (end_stream) begin
         // Flush the last code, then retire the dictionary by bumping the epoch.
         if (push.push0) begin
            push.push1           = 1'b1;
            push.word1.code      = lzwc_pkg::CODE_W'(final_prefix);
            push.word1.last_code = 1'b1;
         end else begin
            push.push0           = 1'b1;
            push.word0.code      = lzwc_pkg::CODE_W'(final_prefix);
            push.word0.last_code = 1'b1;
         end
         prefix_valid_in = 1'b0;
         next_free_in    = (CODE_BITS+1)'(lzwc_pkg::LITERALS);
         epoch_in        = epoch_ff + EB'(1);
         if (epoch_in == '0) begin
            clr_addr_in = '0;
            state_in    = ST_CLEAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         epoch_ff        <= '0;
         prefix_valid_ff <= 1'b0;
         next_free_ff    <= (CODE_BITS+1)'(lzwc_pkg::LITERALS);
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         epoch_ff        <= epoch_in;
         prefix_valid_ff <= prefix_valid_in;
         next_free_ff    <= next_free_in;
      end
      prefix_ff     <= prefix_in;
      byte_ff       <= byte_in;
      eos_ff        <= eos_in;
      probe_addr_ff <= probe_addr_in;
   end

   lzwc_dict_ram #(
      .ADDR_BITS(H),
      .DATA_BITS(DW)
   ) u_dict (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzwc_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word),
      .count     (fifo_count)
   );

   assign rsp_code      = out_word.code;
   assign rsp_last_code = out_word.last_code;

   `ASSERT_IMPLIES(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, req_stall)
   `ASSERT_NEXT(a_lookup_follows, clock, reset, accept && prefix_valid_ff, state_ff == ST_PROBE)
   `ASSERT_IMPLIES(a_probe_has_prefix, clock, reset, state_ff == ST_PROBE, prefix_valid_ff)
   `ASSERT_IMPLIES(a_fifo_bound, clock, reset, 1'b1, fifo_count <= 3'(lzwc_pkg::FIFO_DEPTH))
endmodule

// ===== test/tb_lzw_byte_compressor_core.sv =====
// ---------------------------------------------------------------------------
// LZW byte compressor core testbench
// Streams of bytes go into the compressor with random gaps and output stalls.
// A scoreboard replays each accepted byte through its own LZW encoder and
// compares every emitted code word, field by field, against its expectation.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lzw_byte_compressor_core;

   localparam int NBITS = lzwc_pkg::CODE_BITS_DEFAULT;
   localparam int DICT_LIMIT = 1 << NBITS;

   // Scoreboard: keeps its own copy of the encoder state and a queue of the
   // code words the block still owes us.
   class lzw_scoreboard;
      bit [NBITS-1:0]         cur_prefix;
      bit                     have_prefix;
      int                     free_code;
      int                     pair_index [bit [NBITS+7:0]];
      lzwc_pkg::rsp_word_type owed_words [$];
      int                     errors;
      int                     codes_seen;
      int                     streams_done;
      int                     max_dict;

      function void restart_stream();
         cur_prefix = '0;
         have_prefix = 0;
         free_code = lzwc_pkg::LITERALS;
         pair_index.delete();
      endfunction

      function void owe(bit [NBITS-1:0] c, bit last);
         lzwc_pkg::rsp_word_type w;
         w.code = c[lzwc_pkg::CODE_W-1:0];
         w.last_code = last;
         owed_words = {owed_words, w};
      endfunction

      // Encode one accepted byte and note the words it causes.
      function void note_byte(bit [7:0] b, bit eos);
         bit [NBITS+7:0] key;
         if (!have_prefix) begin
            cur_prefix = NBITS'(b);
            have_prefix = 1;
         end else begin
            key = {cur_prefix, b};
            if (pair_index.exists(key)) begin
               cur_prefix = NBITS'(pair_index[key]);
            end else begin
               owe(cur_prefix, 0);
               if (free_code < DICT_LIMIT) begin
                  pair_index[key] = free_code;
                  free_code++;
               end
               cur_prefix = NBITS'(b);
            end
         end
         if (free_code > max_dict) max_dict = free_code;
         if (eos) begin
            owe(cur_prefix, 1);
            streams_done++;
            restart_stream();
         end
      endfunction

      function void check_word(bit [lzwc_pkg::CODE_W-1:0] c, bit last);
         lzwc_pkg::rsp_word_type w;
         codes_seen++;
         if (owed_words.size() == 0) begin
            $error("unexpected code word: code=%0d last_code=%0d", c, last);
            errors++;
            return;
         end
         w = owed_words.pop_front();
         if (w.code !== c) begin
            $error("code mismatch: expected %0d, actual %0d", w.code, c);
            errors++;
         end
         if (w.last_code !== last) begin
            $error("last_code mismatch: expected %0d, actual %0d", w.last_code, last);
            errors++;
         end
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [7:0]                  req_data_byte;
   logic                        req_end_of_stream;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [lzwc_pkg::CODE_W-1:0] rsp_code;
   logic                        rsp_last_code;

   lzw_byte_compressor_core #(.CODE_BITS(NBITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_data_byte(req_data_byte), .req_end_of_stream(req_end_of_stream),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_code(rsp_code), .rsp_last_code(rsp_last_code)
   );

   lzw_scoreboard board;
   int burst_left;
   int stall_mode;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Hard limit: about 900 bytes, clearing passes after every 15 streams and
   // the slowest receiver together need well under a millisecond.
   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   // Receiver: the stall pattern changes mode now and then, from never
   // stalling to stalling most of the time, so the result queue both drains
   // and fills up against req_stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         unique case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) != 0);
         endcase
         if (rsp_valid && !rsp_stall) board.check_word(rsp_code, rsp_last_code);
      end
   end

   // Send one word and wait until the block has taken it. Bursts of random
   // length alternate with gaps of random length; within a burst req_valid
   // stays high and the next word follows at once.
   task automatic send_byte(input bit [7:0] b, input bit eos);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_stream <= eos;
      do @(posedge clock); while (req_stall);
      board.note_byte(b, eos);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.owed_words.size() != 0);
   endtask

   // One stream of n bytes. Small alphabets give long repeats and so deep
   // dictionary chains; a full alphabet gives mostly misses.
   task automatic send_stream(input int n, input int alpha);
      for (int i = 0; i < n; i++)
         send_byte(alpha >= 256 ? 8'($urandom) : 8'($urandom_range(0, alpha - 1)),
                   i == n - 1);
   endtask

   initial begin
      int sent;
      int len;
      board = new();
      board.restart_stream();
      board.errors = 0;
      board.codes_seen = 0;
      board.streams_done = 0;
      board.max_dict = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_end_of_stream = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: a one-byte stream, byte extremes, a repeated pair that
      // extends the prefix, and an end flag on a miss (two words at once).
      send_byte(8'h00, 1);
      send_byte(8'hFF, 1);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 0);
      send_byte(8'hFF, 0);
      send_byte(8'h00, 1);
      send_byte(8'hAA, 0);
      send_byte(8'h55, 0);
      send_byte(8'hAA, 0);
      send_byte(8'h55, 0);
      send_byte(8'h7F, 0);
      send_byte(8'h80, 1);
      send_byte(8'h41, 0);
      send_byte(8'h41, 0);
      send_byte(8'h41, 0);
      send_byte(8'h41, 1);

      // Pause until every owed word has arrived, then resume.
      wait_drained();

      // Random streams of mostly short length with varied alphabets.
      sent = 0;
      while (sent < 800) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
         send_stream(len, ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 6));
         sent += len;
         if ($urandom_range(0, 15) == 0) wait_drained();
      end

      // One longer stream of random bytes to close the run.
      send_stream(80, 256);

      wait_drained();
      repeat (50) @(posedge clock);

      $display("Run covered %0d streams and %0d code words; largest dictionary next code %0d.",
               board.streams_done, board.codes_seen, board.max_dict);
      if (board.errors == 0 && board.owed_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
